// ===== hw/rtl/ntc_pkg.sv =====
// ----------------------------------------------------------------------------
// ntc_pkg: shared types and constants of the thermistor temperature block
// Command and status structs between controller and datapath, register codes.
// ----------------------------------------------------------------------------
package ntc_pkg;

   localparam int unsigned ADC_BITS_DEF  = 16;
   localparam int unsigned FRAC_BITS_DEF = 16;
   localparam int unsigned LOG_FRAC      = 24;
   localparam int unsigned CSR_IDX_W     = 3;
   localparam int unsigned CSR_DATA_W    = 20;

   localparam logic [16:0] WEIGHT_ONE   = 17'd65536;
   localparam logic [29:0] LN2_Q30      = 30'd744261118;
   localparam logic signed [15:0] TEMP_MAX = 16'sd32767;
   localparam logic signed [15:0] TEMP_MIN = -16'sd27315;
   localparam logic [15:0] ZERO_C_IN_CK = 16'd27315;

   localparam logic [CSR_IDX_W-1:0] REG_LPF_WEIGHT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SERIES     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_NOMINAL    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_NOM_TEMP   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_BETA       = 3'd5;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_LOW  = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FILTER,
      ST_CLASSIFY,
      ST_RES_DIV,
      ST_LOG_LOAD,
      ST_LOG_NORM,
      ST_LOG_ITER,
      ST_LOG_ACC,
      ST_LN_MUL,
      ST_DEN,
      ST_T_LOAD,
      ST_T_DIV,
      ST_FINISH,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load;        // capture sample, compute clamp and filter
      logic classify;    // decide status and special cases
      logic div_start;   // start divider with resistance operands
      logic div_step;    // one quotient bit
      logic log_load;    // select log operand (0..3)
      logic log_norm;    // one normalization step
      logic log_iter;    // one squaring iteration
      logic log_acc;     // accumulate log result
      logic ln_mul;      // scale by ln2
      logic den;         // build beta denominator
      logic tdiv_start;  // start divider with temperature operands
      logic finish;      // finalize output register
   } cmd_type;

   typedef struct packed {
      logic special;     // result known without the log path
      logic res_only;    // skip the temperature path (zero series resistor, zero beta or nominal temperature)
      logic div_done;
      logic norm_done;
      logic iter_done;
      logic log_last;    // last of the four logs selected
      logic den_bad;     // denominator not positive
   } status_type;

endpackage

// ===== hw/rtl/ntc_datapath.sv =====
// ----------------------------------------------------------------------------
// ntc_datapath: filter, shared divider and log2 unit
// One 64-bit restoring divider is shared by the resistance and temperature
// divisions; one squaring unit computes the four log2 terms in turn.
// ----------------------------------------------------------------------------
module ntc_datapath #(
   parameter int unsigned ADC_BITS  = ntc_pkg::ADC_BITS_DEF,
   parameter int unsigned FRAC_BITS = ntc_pkg::FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ntc_pkg::cmd_type     cmd,
   output ntc_pkg::status_type  sts,
   input  logic [15:0]          adc_sample,
   input  logic [16:0]          lpf_weight,
   input  logic signed [13:0]   offset_counts,
   input  logic [19:0]          series_ohms,
   input  logic [19:0]          nominal_ohms,
   input  logic [15:0]          nominal_centikelvin,
   input  logic [13:0]          beta_kelvin,
   output logic signed [15:0]   temp_centi_celsius,
   output logic [31:0]          filtered_level,
   output logic [31:0]          resistance_ohms,
   output logic [1:0]           status
);

   localparam int unsigned LW = ADC_BITS + FRAC_BITS + 1;  // level width
   localparam int unsigned XW = ADC_BITS + 1;              // clamped counts
   localparam int unsigned LOPW = (LW > 32) ? LW : 32;     // log operand width
   localparam int unsigned LF = ntc_pkg::LOG_FRAC;
   localparam logic [LW-1:0] FS = LW'(1) << (ADC_BITS + FRAC_BITS);

   // filter state
   logic [LW-1:0] filt_ff, filt_in;
   logic          first_ff, first_in;
   logic [LW-1:0] lvl_ff, lvl_in;

   // clamp and filter
   logic signed [XW+1:0] x_s;
   logic [XW-1:0]        x_cnt;
   logic [LW-1:0]        x_lvl, prev;
   logic [16:0]          w;
   logic [LW+17:0]       acc;

   always_comb begin
      x_s = $signed({2'b00, adc_sample[ADC_BITS-1:0]}) - (XW+2)'(offset_counts);
      if (x_s < 0) x_cnt = '0;
      else if (x_s > $signed((XW+2)'(1) << ADC_BITS)) x_cnt = XW'(1) << ADC_BITS;
      else x_cnt = x_s[XW-1:0];
      x_lvl = LW'(x_cnt) << FRAC_BITS;
      prev  = first_ff ? x_lvl : filt_ff;
      w     = (lpf_weight > ntc_pkg::WEIGHT_ONE) ? ntc_pkg::WEIGHT_ONE : lpf_weight;
      acc   = (LW+18)'(w) * (LW+18)'(x_lvl)
              + (LW+18)'(ntc_pkg::WEIGHT_ONE - w) * (LW+18)'(prev)
              + (LW+18)'(32768);
      lvl_in   = cmd.load ? acc[LW+15:16] : lvl_ff;
      filt_in  = cmd.load ? acc[LW+15:16] : filt_ff;
      first_in = cmd.load ? 1'b0 : first_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filt_ff  <= '0;
         first_ff <= 1'b1;
      end else begin
         filt_ff  <= filt_in;
         first_ff <= first_in;
      end
      lvl_ff <= lvl_in;
   end

   // shared restoring divider, 64-bit numerator
   logic [63:0] dnum_ff, dnum_in;
   logic [63:0] dden_ff, dden_in;
   logic [64:0] drem_ff, drem_in;
   logic [6:0]  dcnt_ff, dcnt_in;
   logic [64:0] trial;

   // log unit
   logic [1:0]          lsel_ff, lsel_in;
   logic [LOPW-1:0]     lv_ff, lv_in;        // operand being normalized
   logic [5:0]          ln_ff, ln_in;        // integer part
   logic [31:0]         lm_ff, lm_in;        // mantissa Q30 (< 2^31)
   logic [4:0]          li_ff, li_in;        // iteration bit
   logic [LF-1:0]       lr_ff, lr_in;        // fraction of current log
   logic signed [36:0]  ld_ff, ld_in;        // signed sum of logs
   logic [63:0]         sq;
   logic [LOPW-1:0]     lop;
   logic [5:0]          msb;

   // temperature
   logic [63:0]         num_ff, num_in;
   logic signed [37:0]  e_ff, e_in;
   logic signed [63:0]  den_ff, den_in;
   logic [66:0]         pm;
   logic [36:0]         mag;
   logic [1:0]          stat_ff, stat_in;
   logic signed [15:0]  temp_ff, temp_in;
   logic [31:0]         res_ff, res_in;
   logic                special_ff, special_in;
   logic                resonly_ff, resonly_in;
   logic                tphase_ff, tphase_in;
   logic [63:0]         tck;

   always_comb begin
      // operand for the selected log: series, fs-lvl, lvl, nominal
      unique case (lsel_ff)
         2'd0:    lop = LOPW'(series_ohms);
         2'd1:    lop = LOPW'(FS - lvl_ff);
         2'd2:    lop = LOPW'(lvl_ff);
         default: lop = (nominal_ohms == 20'd0) ? LOPW'(1) : LOPW'(nominal_ohms);
      endcase
      msb = 6'(LOPW - 1);
      sq  = 64'(lm_ff) * 64'(lm_ff);
      trial  = {drem_ff[63:0], dnum_ff[63]} - {1'b0, dden_ff};
      mag = ld_ff[36] ? 37'(-ld_ff) : 37'(ld_ff);
      pm  = 67'(mag) * 67'(ntc_pkg::LN2_Q30) + (67'(1) << 29);

      dnum_in = dnum_ff; dden_in = dden_ff; drem_in = drem_ff; dcnt_in = dcnt_ff;
      lsel_in = lsel_ff; lv_in = lv_ff; ln_in = ln_ff; lm_in = lm_ff;
      li_in = li_ff; lr_in = lr_ff; ld_in = ld_ff;
      num_in = num_ff; e_in = e_ff; den_in = den_ff;
      stat_in = stat_ff; temp_in = temp_ff; res_in = res_ff;
      special_in = special_ff; resonly_in = resonly_ff; tphase_in = tphase_ff;
      tck = dnum_ff;

      if (cmd.load) begin
         lsel_in = 2'd0;
         ld_in   = '0;
      end
      if (cmd.classify) begin
         num_in     = (64'(nominal_centikelvin) * 64'(beta_kelvin) * 64'd100) << LF;
         special_in = 1'b0;
         resonly_in = 1'b0;
         stat_in    = ntc_pkg::STATUS_OK;
         if (lvl_ff == '0) begin
            stat_in = ntc_pkg::STATUS_LOW; res_in = '1;
            temp_in = ntc_pkg::TEMP_MIN; special_in = 1'b1;
         end else if (lvl_ff >= FS) begin
            stat_in = ntc_pkg::STATUS_FULL; res_in = '0;
            temp_in = ntc_pkg::TEMP_MAX; special_in = 1'b1;
         end else if (series_ohms == 20'd0) begin
            temp_in = ntc_pkg::TEMP_MAX; resonly_in = 1'b1;
         end else if (nominal_centikelvin == 16'd0 || beta_kelvin == 14'd0) begin
            temp_in = ntc_pkg::TEMP_MIN; resonly_in = 1'b1;
         end
      end
      if (cmd.div_start) begin
         dnum_in = 64'(series_ohms) * 64'(FS - lvl_ff);
         dden_in = 64'(lvl_ff);
         drem_in = '0; dcnt_in = '0; tphase_in = 1'b0;
      end
      if (cmd.tdiv_start) begin
         dnum_in = num_ff + 64'(den_ff[63:1]);
         dden_in = 64'(den_ff);
         drem_in = '0; dcnt_in = '0; tphase_in = 1'b1;
      end
      if (cmd.div_step) begin
         if (!trial[64]) begin
            drem_in = {1'b0, trial[63:0]};
            dnum_in = {dnum_ff[62:0], 1'b1};
         end else begin
            drem_in = {1'b0, drem_ff[62:0], dnum_ff[63]};
            dnum_in = {dnum_ff[62:0], 1'b0};
         end
         dcnt_in = dcnt_ff + 7'd1;
         if (dcnt_ff == 7'd63) begin
            if (!tphase_ff) begin
               res_in = (dnum_in[63:32] != '0) ? '1 : dnum_in[31:0];
            end
         end
      end
      if (cmd.log_load) begin
         lv_in = lop; ln_in = msb; lr_in = '0; li_in = 5'(LF - 1);
      end
      if (cmd.log_norm) begin
         if (lv_ff[LOPW-1]) begin
            // top bit found: its 31 leading bits form the Q30 mantissa
            lm_in = 32'(lv_ff[LOPW-1 -: 31]);
         end else begin
            lv_in = lv_ff << 1;
            ln_in = ln_ff - 6'd1;
         end
      end
      if (cmd.log_iter) begin
         lm_in = sq[61:30];
         if (sq[61]) begin
            lm_in = sq[62:31];
            lr_in = lr_ff | (LF'(1) << li_ff);
         end
         li_in = li_ff - 5'd1;
      end
      if (cmd.log_acc) begin
         if (lsel_ff[1]) ld_in = ld_ff - $signed(37'({ln_ff, lr_ff}));
         else            ld_in = ld_ff + $signed(37'({ln_ff, lr_ff}));
         lsel_in = lsel_ff + 2'd1;
      end
      if (cmd.ln_mul) begin
         e_in = ld_ff[36] ? -38'(pm[66:30]) : 38'(pm[66:30]);
      end
      if (cmd.den) begin
         den_in = $signed((64'(beta_kelvin) * 64'd100) << LF)
                  + 64'(e_ff) * 64'($signed({1'b0, nominal_centikelvin}));
      end
      if (cmd.finish && tphase_ff) begin
         if (tck > 64'(32767 + 27315)) temp_in = ntc_pkg::TEMP_MAX;
         else temp_in = 16'(tck[16:0] - 17'(ntc_pkg::ZERO_C_IN_CK));
      end
      if (cmd.finish && !tphase_ff && den_ff <= 0 && !resonly_ff && !special_ff)
         temp_in = ntc_pkg::TEMP_MAX;
   end

   always_ff @(posedge clock) begin
      dnum_ff <= dnum_in; dden_ff <= dden_in; drem_ff <= drem_in; dcnt_ff <= dcnt_in;
      lsel_ff <= lsel_in; lv_ff <= lv_in; ln_ff <= ln_in; lm_ff <= lm_in;
      li_ff <= li_in; lr_ff <= lr_in; ld_ff <= ld_in;
      num_ff <= num_in; e_ff <= e_in; den_ff <= den_in;
      stat_ff <= stat_in; temp_ff <= temp_in; res_ff <= res_in;
      special_ff <= special_in; resonly_ff <= resonly_in; tphase_ff <= tphase_in;
   end

   assign sts.special   = special_ff;
   assign sts.res_only  = resonly_ff;
   assign sts.div_done  = (dcnt_ff == 7'd63);
   assign sts.norm_done = lv_ff[LOPW-1];
   assign sts.iter_done = (li_ff == 5'd0);
   assign sts.log_last  = (lsel_ff == 2'd3);
   assign sts.den_bad   = (den_ff <= 0);

   assign temp_centi_celsius = temp_ff;
   assign filtered_level     = (lvl_ff > LW'(32'hFFFF_FFFF)) ? '1 : 32'(lvl_ff);
   assign resistance_ohms    = res_ff;
   assign status             = stat_ff;

endmodule

// ===== hw/rtl/ntc_controller.sv =====
// ----------------------------------------------------------------------------
// ntc_controller: sequencer for the thermistor temperature block
// Steps one item through filter, resistance division, four log2 terms,
// ln scaling, denominator and temperature division.
// ----------------------------------------------------------------------------
module ntc_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  ntc_pkg::status_type sts,
   output ntc_pkg::cmd_type    cmd
);

   ntc_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ntc_pkg::ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ntc_pkg::ST_IDLE:     if (req_valid) state_in = ntc_pkg::ST_FILTER;
         ntc_pkg::ST_FILTER:   state_in = ntc_pkg::ST_CLASSIFY;
         ntc_pkg::ST_CLASSIFY: state_in = ntc_pkg::ST_RES_DIV;
         ntc_pkg::ST_RES_DIV: begin
            if (sts.div_done) begin
               if (sts.special || sts.res_only) state_in = ntc_pkg::ST_OUT;
               else state_in = ntc_pkg::ST_LOG_LOAD;
            end
         end
         ntc_pkg::ST_LOG_LOAD: state_in = ntc_pkg::ST_LOG_NORM;
         ntc_pkg::ST_LOG_NORM: if (sts.norm_done) state_in = ntc_pkg::ST_LOG_ITER;
         ntc_pkg::ST_LOG_ITER: if (sts.iter_done) state_in = ntc_pkg::ST_LOG_ACC;
         ntc_pkg::ST_LOG_ACC: begin
            if (sts.log_last) state_in = ntc_pkg::ST_LN_MUL;
            else state_in = ntc_pkg::ST_LOG_LOAD;
         end
         ntc_pkg::ST_LN_MUL:   state_in = ntc_pkg::ST_DEN;
         ntc_pkg::ST_DEN:      state_in = ntc_pkg::ST_T_LOAD;
         ntc_pkg::ST_T_LOAD:   state_in = sts.den_bad ? ntc_pkg::ST_FINISH : ntc_pkg::ST_T_DIV;
         ntc_pkg::ST_T_DIV:    if (sts.div_done) state_in = ntc_pkg::ST_FINISH;
         ntc_pkg::ST_FINISH:   state_in = ntc_pkg::ST_OUT;
         ntc_pkg::ST_OUT:      if (!rsp_stall) state_in = ntc_pkg::ST_IDLE;
         default:              state_in = ntc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ntc_pkg::ST_IDLE:     cmd.load = req_valid;
         ntc_pkg::ST_FILTER:   cmd.classify = 1'b1;
         ntc_pkg::ST_CLASSIFY: cmd.div_start = 1'b1;
         ntc_pkg::ST_RES_DIV:  cmd.div_step = 1'b1;
         ntc_pkg::ST_LOG_LOAD: cmd.log_load = 1'b1;
         ntc_pkg::ST_LOG_NORM: cmd.log_norm = 1'b1;
         ntc_pkg::ST_LOG_ITER: cmd.log_iter = 1'b1;
         ntc_pkg::ST_LOG_ACC:  cmd.log_acc = 1'b1;
         ntc_pkg::ST_LN_MUL:   cmd.ln_mul = 1'b1;
         ntc_pkg::ST_DEN:      cmd.den = 1'b1;
         // skip the division when the denominator is not positive
         ntc_pkg::ST_T_LOAD:   cmd.tdiv_start = !sts.den_bad;
         ntc_pkg::ST_T_DIV:    cmd.div_step = 1'b1;
         ntc_pkg::ST_FINISH:   cmd.finish = 1'b1;
         ntc_pkg::ST_OUT:      ;
         default:              ;
      endcase
   end

   assign req_stall = (state_ff != ntc_pkg::ST_IDLE);
   assign rsp_valid = (state_ff == ntc_pkg::ST_OUT);

endmodule

// ===== hw/rtl/ntc_thermistor_temperature.sv =====
// ----------------------------------------------------------------------------
// ntc_thermistor_temperature: NTC thermistor temperature from ADC samples
// Offset, first-order low-pass filter, divider resistance and beta equation.
// ----------------------------------------------------------------------------
// One item at a time: the run of each item is set by the shared 64-step
// restoring divider (used twice) and the four 24-step squaring log2 passes,
// each behind a normalization of one shift per leading zero of its operand.
// Items with the level at or below zero or at full scale, a zero series
// resistor, or a zero beta or nominal temperature skip the log path.
module ntc_thermistor_temperature #(
   parameter int unsigned ADC_BITS  = ntc_pkg::ADC_BITS_DEF,
   parameter int unsigned FRAC_BITS = ntc_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [15:0]                       req_adc_sample,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [15:0]                rsp_temp_centi_celsius,
   output logic [31:0]                       rsp_filtered_level,
   output logic [31:0]                       rsp_resistance_ohms,
   output logic [1:0]                        rsp_status,
   input  logic                              csr_write,
   input  logic [ntc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ntc_pkg::CSR_DATA_W-1:0]    csr_data
);

   logic [16:0]        weight_ff;
   logic signed [13:0] offset_ff;
   logic [19:0]        series_ff, nominal_ff;
   logic [15:0]        nomtemp_ff;
   logic [13:0]        beta_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff  <= 17'd6554;
         offset_ff  <= '0;
         series_ff  <= 20'd50000;
         nominal_ff <= 20'd50000;
         nomtemp_ff <= 16'd29815;
         beta_ff    <= 14'd3950;
      end else if (csr_write) begin
         unique case (csr_index)
            ntc_pkg::REG_LPF_WEIGHT: weight_ff  <= csr_data[16:0];
            ntc_pkg::REG_OFFSET:     offset_ff  <= csr_data[13:0];
            ntc_pkg::REG_SERIES:     series_ff  <= csr_data;
            ntc_pkg::REG_NOMINAL:    nominal_ff <= csr_data;
            ntc_pkg::REG_NOM_TEMP:   nomtemp_ff <= csr_data[15:0];
            ntc_pkg::REG_BETA:       beta_ff    <= csr_data[13:0];
            default:                 ;
         endcase
      end
   end

   ntc_pkg::cmd_type    cmd;
   ntc_pkg::status_type sts;

   ntc_controller u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .sts, .cmd
   );

   ntc_datapath #(.ADC_BITS(ADC_BITS), .FRAC_BITS(FRAC_BITS)) u_dp (
      .clock, .reset, .cmd, .sts,
      .adc_sample          (req_adc_sample),
      .lpf_weight          (weight_ff),
      .offset_counts       (offset_ff),
      .series_ohms         (series_ff),
      .nominal_ohms        (nominal_ff),
      .nominal_centikelvin (nomtemp_ff),
      .beta_kelvin         (beta_ff),
      .temp_centi_celsius  (rsp_temp_centi_celsius),
      .filtered_level      (rsp_filtered_level),
      .resistance_ohms     (rsp_resistance_ohms),
      .status              (rsp_status)
   );

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("input taken while result pending");
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ntc_pkg::STATUS_FULL |-> rsp_resistance_ohms == '0)
      else $error("full scale with nonzero resistance");

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: thermistor temperature block testbench
// Drives ADC samples and register writes with random gaps and stalls, predicts
// each reading (offset, low-pass filter, resistance, beta equation) in a small
// scoreboard and checks every result field by field.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [ntc_pkg::CSR_IDX_W-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [ntc_pkg::CSR_IDX_W-1:0] REG_SPARE_HI = 3'd7;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE_CYCLES = 250;
   localparam longint unsigned FS_LEVEL = 64'd1 << 32;
   localparam logic [15:0] FIRST_SAMPLES [6] =
      '{16'd32768, 16'd0, 16'd65535, 16'd1, 16'h5555, 16'hAAAA};

   typedef struct packed {
      logic signed [15:0] temp;
      logic [31:0]        level;
      logic [31:0]        ohms;
      logic [1:0]         status;
   } reading_t;

   class reading_board;
      logic [16:0]        weight;
      logic signed [13:0] offset;
      logic [19:0]        series;
      logic [19:0]        nominal;
      logic [15:0]        nom_ck;
      logic [13:0]        beta;
      longint unsigned    level_state;
      bit                 seeded;
      reading_t           expected_readings[$];
      int                 fails;

      function new();
         weight = 17'd6554;
         offset = '0;
         series = 20'd50000;
         nominal = 20'd50000;
         nom_ck = 16'd29815;
         beta = 14'd3950;
         level_state = 0;
         seeded = 0;
         fails = 0;
      endfunction

      function void set_reg(logic [ntc_pkg::CSR_IDX_W-1:0] idx,
                            logic [ntc_pkg::CSR_DATA_W-1:0] d);
         case (idx)
            ntc_pkg::REG_LPF_WEIGHT: weight = d[16:0];
            ntc_pkg::REG_OFFSET:     offset = d[13:0];
            ntc_pkg::REG_SERIES:     series = d;
            ntc_pkg::REG_NOMINAL:    nominal = d;
            ntc_pkg::REG_NOM_TEMP:   nom_ck = d[15:0];
            ntc_pkg::REG_BETA:       beta = d[13:0];
            default: ;
         endcase
      endfunction

      function longint unsigned log2_q24(longint unsigned v);
         int n;
         longint unsigned t, m, r;
         n = 0;
         t = v;
         while (t > 1) begin
            t >>= 1;
            n++;
         end
         m = (n >= 30) ? (v >> (n - 30)) : (v << (30 - n));
         r = longint'(n) << ntc_pkg::LOG_FRAC;
         for (int i = ntc_pkg::LOG_FRAC - 1; i >= 0; i--) begin
            m = (m * m) >> 30;
            if (m >= (64'd1 << 31)) begin
               m >>= 1;
               r |= 64'd1 << i;
            end
         end
         return r;
      endfunction

      function logic signed [15:0] beta_temp(longint unsigned lvl);
         longint unsigned nom, num, mag, p, tck;
         longint d, e, den;
         nom = (nominal == 0) ? 1 : nominal;
         if (series == 0) return ntc_pkg::TEMP_MAX;
         num = (64'd100 * nom_ck * beta) << ntc_pkg::LOG_FRAC;
         if (num == 0) return ntc_pkg::TEMP_MIN;
         d = longint'(log2_q24(series) + log2_q24(FS_LEVEL - lvl))
           - longint'(log2_q24(lvl) + log2_q24(nom));
         mag = (d < 0) ? -d : d;
         p = (mag * ntc_pkg::LN2_Q30 + (64'd1 << 29)) >> 30;
         e = (d < 0) ? -longint'(p) : longint'(p);
         den = longint'((64'd100 * beta) << ntc_pkg::LOG_FRAC) + longint'(nom_ck) * e;
         if (den <= 0) return ntc_pkg::TEMP_MAX;
         tck = (num + longint'(unsigned'(den)) / 2) / longint'(unsigned'(den));
         if (tck > 32767 + 27315) return ntc_pkg::TEMP_MAX;
         return 16'(longint'(tck) - 27315);
      endfunction

      // advance the filter and queue the reading this sample produces
      function void note_sample(logic [15:0] s);
         longint xc;
         longint unsigned x, prev, w, lvl, res;
         reading_t r;
         xc = longint'(s) - longint'(offset);
         if (xc < 0) xc = 0;
         if (xc > 65536) xc = 65536;
         x = longint'(xc) << 16;
         prev = seeded ? level_state : x;
         seeded = 1;
         w = (weight > ntc_pkg::WEIGHT_ONE) ? ntc_pkg::WEIGHT_ONE : weight;
         lvl = (w * x + (65536 - w) * prev + 32768) >> 16;
         level_state = lvl;
         if (lvl == 0) begin
            r.status = ntc_pkg::STATUS_LOW;
            r.ohms = 32'hFFFF_FFFF;
            r.temp = ntc_pkg::TEMP_MIN;
         end else if (lvl >= FS_LEVEL) begin
            r.status = ntc_pkg::STATUS_FULL;
            r.ohms = 0;
            r.temp = ntc_pkg::TEMP_MAX;
         end else begin
            r.status = ntc_pkg::STATUS_OK;
            res = (longint'(series) * (FS_LEVEL - lvl)) / lvl;
            r.ohms = (res > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : res[31:0];
            r.temp = beta_temp(lvl);
         end
         r.level = (lvl > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : lvl[31:0];
         expected_readings.push_back(r);
      endfunction

      task report(string what, longint got, longint want);
         $display("error: %s got %0d expected %0d", what, got, want);
         fails++;
      endtask

      task check_reading(reading_t got);
         reading_t want;
         if (expected_readings.size() == 0) begin
            report("unexpected result, level", got.level, 0);
            return;
         end
         want = expected_readings.pop_front();
         if (got.temp != want.temp) report("temp_centi_celsius", got.temp, want.temp);
         if (got.level != want.level) report("filtered_level", got.level, want.level);
         if (got.ohms != want.ohms) report("resistance_ohms", got.ohms, want.ohms);
         if (got.status != want.status) report("status", got.status, want.status);
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [15:0] req_adc_sample = '0;
   logic rsp_valid;
   logic rsp_stall = 1;
   logic signed [15:0] rsp_temp_centi_celsius;
   logic [31:0] rsp_filtered_level;
   logic [31:0] rsp_resistance_ohms;
   logic [1:0] rsp_status;
   logic csr_write = 0;
   logic [ntc_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [ntc_pkg::CSR_DATA_W-1:0] csr_data = '0;

   reading_board board = new();
   bit quiet = 0;
   bit long_hold = 0;
   int cycles = 0;

   ntc_thermistor_temperature DUT (
      .clock, .reset, .req_valid, .req_stall, .req_adc_sample,
      .rsp_valid, .rsp_stall, .rsp_temp_centi_celsius, .rsp_filtered_level,
      .rsp_resistance_ohms, .rsp_status, .csr_write, .csr_index, .csr_data
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("ntc_thermistor_temperature: mismatch");
         $finish;
      end
      if (!reset) begin
         if (req_valid && !req_stall) board.note_sample(req_adc_sample);
         if (rsp_valid && !rsp_stall)
            board.check_reading({rsp_temp_centi_celsius, rsp_filtered_level,
                                 rsp_resistance_ohms, rsp_status});
      end
   end

   // receiver: random hold-off before each item, one long hold on request
   initial begin
      int n;
      @(negedge clock);
      forever begin
         n = long_hold ? 3000 : (quiet ? 0 : $urandom_range(0, 8));
         long_hold = 0;
         if (n > 0) begin
            rsp_stall <= 1;
            repeat (n) @(negedge clock);
         end
         rsp_stall <= 0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   task write_reg(logic [ntc_pkg::CSR_IDX_W-1:0] idx, logic [ntc_pkg::CSR_DATA_W-1:0] d);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= d;
      board.set_reg(idx, d);
      @(negedge clock);
      csr_write <= 0;
      @(negedge clock);
   endtask

   task send_sample(logic [15:0] s);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1;
      req_adc_sample <= s;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // hold the input until every reading is back and the block has settled
   task drain;
      req_valid <= 0;
      do @(negedge clock); while (board.expected_readings.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function logic [15:0] pick_sample();
      case ($urandom_range(0, 9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'(($urandom_range(0, 255)));
         3: return 16'hFFFF - 16'($urandom_range(0, 255));
         default: return 16'($urandom);
      endcase
   endfunction

   function logic [ntc_pkg::CSR_DATA_W-1:0] pick_value(logic [ntc_pkg::CSR_DATA_W-1:0] lo,
                                                       logic [ntc_pkg::CSR_DATA_W-1:0] hi);
      case ($urandom_range(0, 5))
         0: return lo;
         1: return hi;
         2: return 20'($urandom);
         default: return 20'($urandom_range(lo, hi));
      endcase
   endfunction

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // defaults, first sample seeds the filter
      for (int i = 0; i < 6; i++) send_sample(FIRST_SAMPLES[i]);
      drain();

      // weight above one, negative offset drives level to full scale
      write_reg(ntc_pkg::REG_LPF_WEIGHT, 20'h1FFFF);
      write_reg(ntc_pkg::REG_OFFSET, 20'hFF000);
      send_sample(16'hFFFF);
      send_sample(16'h0000);
      send_sample(16'h8000);
      drain();
      // positive offset clamps a sample below it to zero level
      write_reg(ntc_pkg::REG_OFFSET, 20'd4096);
      send_sample(16'd100);
      send_sample(16'd4097);
      drain();
      write_reg(ntc_pkg::REG_OFFSET, 20'd0);
      write_reg(ntc_pkg::REG_SERIES, 20'd0);
      send_sample(16'd30000);
      drain();
      write_reg(ntc_pkg::REG_SERIES, 20'd1000000);
      write_reg(ntc_pkg::REG_NOMINAL, 20'd0);
      send_sample(16'd20000);
      drain();
      write_reg(ntc_pkg::REG_BETA, 20'd0);
      send_sample(16'd20000);
      drain();
      write_reg(ntc_pkg::REG_BETA, 20'd3950);
      write_reg(ntc_pkg::REG_NOM_TEMP, 20'd0);
      send_sample(16'd20000);
      drain();
      // hot end beyond the beta equation: tiny resistance ratio, beta of one
      write_reg(ntc_pkg::REG_NOM_TEMP, 20'd40000);
      write_reg(ntc_pkg::REG_SERIES, 20'd1);
      write_reg(ntc_pkg::REG_NOMINAL, 20'd1000000);
      write_reg(ntc_pkg::REG_BETA, 20'd1);
      send_sample(16'd65500);
      drain();
      write_reg(REG_SPARE_LO, 20'hFFFFF);
      write_reg(REG_SPARE_HI, 20'hFFFFF);
      write_reg(ntc_pkg::REG_BETA, 20'd10000);
      send_sample(16'd65500);
      drain();

      for (int ph = 0; ph < 12; ph++) begin
         quiet = (ph % 4 == 3);
         write_reg(ntc_pkg::REG_LPF_WEIGHT, ($urandom_range(0, 3) == 0) ? 20'($urandom)
                                   : pick_value(20'd0, 20'd65536));
         write_reg(ntc_pkg::REG_OFFSET, ($urandom_range(0, 1) == 0) ? 20'($urandom)
                               : 20'($signed(14'($urandom_range(0, 8192)) - 14'sd4096)));
         write_reg(ntc_pkg::REG_SERIES, pick_value(20'd1, 20'd1000000));
         write_reg(ntc_pkg::REG_NOMINAL, pick_value(20'd1, 20'd1000000));
         write_reg(ntc_pkg::REG_NOM_TEMP, pick_value(20'd20000, 20'd40000));
         write_reg(ntc_pkg::REG_BETA, pick_value(20'd1000, 20'd10000));
         if (ph == 5) long_hold = 1;
         repeat (60) send_sample(pick_sample());
         drain();
      end

      if (board.fails == 0)
         $display("ntc_thermistor_temperature: match");
      else
         $display("ntc_thermistor_temperature: mismatch");
      $finish;
   end
endmodule
